// File: sv/hbe_pkg.sv
// Shared types and constants for the Hill cipher block encryptor.
// Depends on nothing; every other file of the block imports it.
package hbe_pkg;

    localparam int KEY_DIM  = 3;
    localparam int LETTER_W = 5;
    localparam int KEY_W    = KEY_DIM * LETTER_W;
    localparam int SIZE_W   = 2;
    localparam int PROD_W   = 2 * LETTER_W;
    localparam int SUM_W    = 12;
    localparam int Q_W      = 8;

    localparam logic [SUM_W-1:0] MODULUS   = 12'd26;
    localparam logic [SUM_W-1:0] RECIP_MUL = 12'd2521;
    localparam int               RECIP_SH  = 16;

    localparam logic [1:0] REG_BLOCK_SIZE   = 2'd0;
    localparam logic [1:0] REG_KEY_ROW_ZERO = 2'd1;
    localparam logic [1:0] REG_KEY_ROW_ONE  = 2'd2;
    localparam logic [1:0] REG_KEY_ROW_TWO  = 2'd3;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [SIZE_W-1:0]   t_size;
    typedef logic [KEY_W-1:0]    t_key_row;

    typedef struct packed {
        t_letter [KEY_DIM-1:0] letters;
        t_size                 size;
    } t_block;

endpackage

// File: sv/hbe_front.sv
// Front end: collects plaintext words into a block and hands complete or flushed
// blocks to the block queue. Depends on hbe_pkg.
module hbe_front #(
    parameter int MAX_BLOCK = 3
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clear,
    input  hbe_pkg::t_size i_size,
    input  logic           i_push,
    input  logic           i_q_full,
    input  hbe_pkg::t_letter i_letter,
    input  logic           i_end_of_message,
    output logic           o_full,
    output logic           o_q_push,
    output hbe_pkg::t_block o_block
);
    import hbe_pkg::*;

    t_letter       r_let [MAX_BLOCK];
    t_size         r_fill;
    t_size         n_fill;
    logic          accept;
    logic          complete;
    logic [SIZE_W:0] count;

    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign count    = {1'b0, r_fill} + {{SIZE_W{1'b0}}, 1'b1};
    assign complete = (count == {1'b0, i_size}) || i_end_of_message;
    assign o_q_push = accept && complete;

    always_comb begin
        o_block.size = i_size;
        for (int c = 0; c < KEY_DIM; c++) begin
            o_block.letters[c] = '0;
            if (c < MAX_BLOCK) begin
                if (SIZE_W'(c) < r_fill) begin
                    o_block.letters[c] = r_let[c];
                end else if (SIZE_W'(c) == r_fill) begin
                    o_block.letters[c] = i_letter;
                end
            end
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (i_clear) begin
            n_fill = '0;
        end else if (accept) begin
            n_fill = complete ? '0 : count[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < MAX_BLOCK; c++) begin
            if (accept && r_fill == SIZE_W'(c)) begin
                r_let[c] <= i_letter;
            end
        end
    end

endmodule

// File: sv/hbe_queue.sv
// Two-entry queue of blocks between the front end and the back end.
// Depends on hbe_pkg.
module hbe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hbe_pkg::t_block i_block,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output hbe_pkg::t_block o_block
);
    import hbe_pkg::*;

    t_block     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_block = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_block;
        end
    end

endmodule

// File: sv/hbe_back.sv
// Back end: issues one key row per cycle while its output queue has room, forms the dot
// product, reduces it modulo 26 and queues the cipher words. Depends on hbe_pkg.
module hbe_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hbe_pkg::t_key_row [hbe_pkg::KEY_DIM-1:0] i_key,
    input  logic             i_valid,
    input  hbe_pkg::t_block  i_block,
    output logic             o_deq,
    input  logic             i_pop,
    output logic             o_empty,
    output hbe_pkg::t_letter o_cipher_letter,
    output logic             o_last_of_block
);
    import hbe_pkg::*;

    localparam logic [2:0] OUT_DEPTH = 3'd4;

    typedef struct packed {
        t_letter cipher;
        logic    last;
    } t_out;

    t_size              r_row;
    t_size              n_row;
    logic               r_v1;
    logic [SUM_W-1:0]   r_sum;
    logic               r_last1;
    t_out               r_fifo [4];
    logic [1:0]         r_wptr;
    logic [1:0]         r_rptr;
    logic [2:0]         r_ocnt;
    logic [2:0]         n_ocnt;
    logic               issue;
    logic               row_last;
    logic [SUM_W-1:0]   sum;
    logic [PROD_W-1:0]  prod;
    t_letter            kent;
    logic [2*SUM_W-1:0] recip;
    logic [Q_W-1:0]     quo;
    logic [SUM_W-1:0]   rem;
    logic [SUM_W-1:0]   red;
    logic               do_pop;
    t_out               wr_word;

    assign issue    = i_valid && ((r_ocnt + {2'b00, r_v1}) < OUT_DEPTH);
    assign row_last = ((r_row + 2'd1) == i_block.size);
    assign o_deq    = issue && row_last;

    always_comb begin
        n_row = r_row;
        if (issue) begin
            n_row = row_last ? '0 : r_row + 2'd1;
        end
    end

    always_comb begin
        sum  = '0;
        kent = '0;
        prod = '0;
        for (int c = 0; c < KEY_DIM; c++) begin
            kent = i_key[r_row][LETTER_W*(KEY_DIM-1-c) +: LETTER_W];
            prod = kent * i_block.letters[c];
            sum  = sum + {{(SUM_W-PROD_W){1'b0}}, prod};
        end
    end

    always_comb begin
        recip = r_sum * RECIP_MUL;
        quo   = recip[RECIP_SH +: Q_W];
        rem   = r_sum - ({quo, 4'b0} + {1'b0, quo, 3'b0} + {3'b0, quo, 1'b0});
        red   = (rem >= MODULUS) ? rem - MODULUS : rem;
        wr_word.cipher = red[LETTER_W-1:0];
        wr_word.last   = r_last1;
    end

    assign do_pop          = i_pop && (r_ocnt != 3'd0);
    assign o_empty         = (r_ocnt == 3'd0);
    assign o_cipher_letter = r_fifo[r_rptr].cipher;
    assign o_last_of_block = r_fifo[r_rptr].last;

    always_comb begin
        n_ocnt = r_ocnt;
        if (r_v1 && !do_pop) begin
            n_ocnt = r_ocnt + 3'd1;
        end else if (do_pop && !r_v1) begin
            n_ocnt = r_ocnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_v1   <= 1'b0;
            r_wptr <= '0;
            r_rptr <= '0;
            r_ocnt <= '0;
        end else begin
            r_row  <= n_row;
            r_v1   <= issue;
            r_ocnt <= n_ocnt;
            if (r_v1) begin
                r_wptr <= r_wptr + 2'd1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_sum   <= sum;
            r_last1 <= row_last;
        end
        if (r_v1) begin
            r_fifo[r_wptr] <= wr_word;
        end
    end

endmodule

// File: sv/hill_block_encrypt_top.sv
// Top level of the Hill cipher block encryptor: configuration registers, front end,
// block queue and back end. Depends on hbe_pkg, hbe_front, hbe_queue and hbe_back.
//
//   Channel    Handshake          Payload
//   input      push / full        i_letter, i_end_of_message
//   result     empty / pop        o_cipher_letter, o_last_of_block
//   config     i_cfg_we           i_cfg_idx, i_cfg_data
//
// One plaintext word is taken every cycle unless full; a block of n words leaves as n
// cipher words, one per cycle while the output queue has room, set by the single
// multiply-accumulate row unit in the back end. A completing block is held in the block
// queue, its rows are registered in the back end's sum register and then written to the
// output queue that drives the result side. Reset is synchronous and clears all control
// state, sets the block size to two and the key to zero. full rises when the two block
// entries are taken; the back end holds off while its four-word output queue is full.
module hill_block_encrypt_top #(
    parameter int MAX_BLOCK = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  hbe_pkg::t_letter       i_letter,
    input  logic                   i_end_of_message,
    output logic                   empty,
    input  logic                   pop,
    output hbe_pkg::t_letter       o_cipher_letter,
    output logic                   o_last_of_block,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  hbe_pkg::t_key_row      i_cfg_data
);
    import hbe_pkg::*;

    t_size                    r_block_size;
    t_key_row [KEY_DIM-1:0]   r_key;
    t_size                    eff_size;
    logic                     clear;
    logic                     q_push;
    logic                     q_full;
    logic                     q_valid;
    logic                     q_pop;
    t_block                   f_block;
    t_block                   b_block;

    assign clear = i_cfg_we && (i_cfg_idx == REG_BLOCK_SIZE);

    always_comb begin
        eff_size = r_block_size;
        if (r_block_size == '0) begin
            eff_size = SIZE_W'(1);
        end else if (r_block_size > SIZE_W'(MAX_BLOCK)) begin
            eff_size = SIZE_W'(MAX_BLOCK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= SIZE_W'(2);
            r_key        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCK_SIZE:   r_block_size <= i_cfg_data[SIZE_W-1:0];
                REG_KEY_ROW_ZERO: r_key[0]     <= i_cfg_data;
                REG_KEY_ROW_ONE:  r_key[1]     <= i_cfg_data;
                REG_KEY_ROW_TWO:  r_key[2]     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hbe_front #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_clear          (clear),
        .i_size           (eff_size),
        .i_push           (push),
        .i_q_full         (q_full),
        .i_letter         (i_letter),
        .i_end_of_message (i_end_of_message),
        .o_full           (full),
        .o_q_push         (q_push),
        .o_block          (f_block)
    );

    hbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_block (f_block),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_block (b_block)
    );

    hbe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_key           (r_key),
        .i_valid         (q_valid),
        .i_block         (b_block),
        .o_deq           (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_cipher_letter (o_cipher_letter),
        .o_last_of_block (o_last_of_block)
    );

endmodule

// File: sim/tb_hill_block_encrypt_top.sv
// Testbench for hill_block_encrypt_top: sends plaintext words, predicts every cipher word
// with its own Hill cipher model and checks each popped word in order.
// Depends on hbe_pkg and the RTL of the block.
module tb_hill_block_encrypt_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hbe_pkg::*;

    localparam int MAX_BLOCK    = 3;
    localparam int LETTER_MOD   = 26;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        t_letter cipher;
        logic    last;
    } t_cipher_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_letter    i_letter = '0;
    logic       i_end_of_message = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    t_letter    o_cipher_letter;
    logic       o_last_of_block;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    t_key_row   i_cfg_data = '0;

    t_size        model_size;
    t_key_row     model_key [KEY_DIM];
    t_letter      held_letters [KEY_DIM];
    int           held_count;
    t_cipher_word pending_ciphers [$];

    int failures = 0;
    int send_idle_pct = 0;
    int pop_idle_pct = 0;
    int pop_hold_cycles = 0;
    int stall_cycles = 0;

    hill_block_encrypt_top #(
        .MAX_BLOCK(MAX_BLOCK)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_letter(i_letter),
        .i_end_of_message(i_end_of_message),
        .empty(empty),
        .pop(pop),
        .o_cipher_letter(o_cipher_letter),
        .o_last_of_block(o_last_of_block),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void encrypt_word(t_letter letter, logic eom);
        int n;
        int sum;
        t_cipher_word word;
        n = (model_size == 0) ? 1 : ((model_size > MAX_BLOCK) ? MAX_BLOCK : int'(model_size));
        if (held_count >= n) held_count = 0;
        held_letters[held_count] = letter;
        held_count++;
        if (held_count < n && !eom) return;
        for (int r = 0; r < n; r++) begin
            sum = 0;
            for (int c = 0; c < n; c++) begin
                if (c < held_count) begin
                    sum += int'(model_key[r][(2 - c) * LETTER_W +: LETTER_W])
                           * int'(held_letters[c]);
                end
            end
            word.cipher = t_letter'(sum % LETTER_MOD);
            word.last = (r == n - 1);
            pending_ciphers.push_back(word);
        end
        held_count = 0;
        foreach (held_letters[i]) held_letters[i] = '0;
    endfunction

    function automatic t_key_row pack_row(int a, int b, int c);
        return {t_letter'(a), t_letter'(b), t_letter'(c)};
    endfunction

    function automatic t_letter random_letter();
        if ($urandom_range(99) < 90) return t_letter'($urandom_range(25));
        return t_letter'($urandom_range(31, 26));
    endfunction

    function automatic t_key_row random_key_row();
        if ($urandom_range(1)) return t_key_row'($urandom());
        return pack_row($urandom_range(25), $urandom_range(25), $urandom_range(25));
    endfunction

    task automatic send_word(t_letter letter, logic eom);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_letter <= letter;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        encrypt_word(letter, eom);
    endtask

    // The block may still be working on a word that completes no block, so the
    // drain also covers the pipeline latency before any register is touched.
    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_ciphers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, t_key_row data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_BLOCK_SIZE: begin
                model_size = t_size'(data);
                held_count = 0;
            end
            REG_KEY_ROW_ZERO: model_key[0] = data;
            REG_KEY_ROW_ONE:  model_key[1] = data;
            REG_KEY_ROW_TWO:  model_key[2] = data;
            default: ;
        endcase
    endtask

    task automatic test_reset_state();
        send_word(t_letter'(3), 1'b0);
        send_word(t_letter'(20), 1'b0);
    endtask

    task automatic test_extremes();
        settle();
        write_reg(REG_BLOCK_SIZE, t_key_row'(3));
        write_reg(REG_KEY_ROW_ZERO, 15'h7FFF);
        write_reg(REG_KEY_ROW_ONE, 15'h7FFF);
        write_reg(REG_KEY_ROW_TWO, 15'h7FFF);
        repeat (3) send_word(t_letter'(31), 1'b0);
        send_word(t_letter'(0), 1'b0);
        send_word(t_letter'(0), 1'b0);
        send_word(t_letter'(0), 1'b1);
    endtask

    task automatic test_end_of_message();
        settle();
        write_reg(REG_KEY_ROW_ZERO, pack_row(25, 0, 17));
        write_reg(REG_KEY_ROW_ONE, pack_row(3, 25, 1));
        write_reg(REG_KEY_ROW_TWO, pack_row(11, 8, 25));
        send_word(t_letter'(25), 1'b1);
        send_word(t_letter'(7), 1'b0);
        send_word(t_letter'(9), 1'b1);
    endtask

    task automatic test_size_rewrite();
        send_word(t_letter'(5), 1'b0);
        settle();
        write_reg(REG_BLOCK_SIZE, t_key_row'(3));
        send_word(t_letter'(1), 1'b0);
        send_word(t_letter'(2), 1'b0);
        send_word(t_letter'(3), 1'b0);
    endtask

    task automatic test_size_limits();
        settle();
        write_reg(REG_BLOCK_SIZE, 15'h7FFC);
        send_word(t_letter'(13), 1'b0);
        send_word(t_letter'(31), 1'b1);
        settle();
        write_reg(REG_BLOCK_SIZE, t_key_row'(2));
        send_word(t_letter'(4), 1'b1);
        send_word(t_letter'(4), 1'b0);
        send_word(t_letter'(5), 1'b0);
    endtask

    task automatic test_random_traffic(t_size size, int words);
        int sent;
        int len;
        logic tidy;
        settle();
        write_reg(REG_BLOCK_SIZE, {13'($urandom()), size});
        write_reg(REG_KEY_ROW_ZERO, random_key_row());
        write_reg(REG_KEY_ROW_ONE, random_key_row());
        write_reg(REG_KEY_ROW_TWO, random_key_row());
        sent = 0;
        while (sent < words) begin
            len = $urandom_range(8, 1);
            tidy = ($urandom_range(99) < 85);
            for (int k = 0; k < len; k++) begin
                send_word(random_letter(),
                          tidy ? logic'(k == len - 1) : logic'($urandom_range(1)));
            end
            sent += len;
        end
    endtask

    // The receiver stops popping for a long stretch while words keep coming,
    // so the block fills up and must raise full.
    task automatic test_backpressure();
        settle();
        write_reg(REG_BLOCK_SIZE, t_key_row'(3));
        pop_hold_cycles = HOLD_CYCLES;
        for (int k = 0; k < 36; k++) begin
            send_word(random_letter(), logic'(k % 9 == 8));
        end
    endtask

    always @(negedge i_clk) begin
        if (pop_hold_cycles > 0) begin
            pop <= 1'b0;
            pop_hold_cycles--;
        end else begin
            pop <= ($urandom_range(99) >= pop_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_cipher_word want;
        if (i_rst_n && pop && !empty) begin
            if (pending_ciphers.size() == 0) begin
                $error("unexpected cipher word: cipher_letter %0d last_of_block %0b",
                       o_cipher_letter, o_last_of_block);
                failures++;
            end else begin
                want = pending_ciphers.pop_front();
                if (o_cipher_letter !== want.cipher) begin
                    $error("cipher_letter: expected %0d, got %0d", want.cipher, o_cipher_letter);
                    failures++;
                end
                if (o_last_of_block !== want.last) begin
                    $error("last_of_block: expected %0b, got %0b", want.last, o_last_of_block);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("hill_block_encrypt_top: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        model_size = t_size'(2);
        held_count = 0;
        foreach (model_key[i]) model_key[i] = '0;
        foreach (held_letters[i]) held_letters[i] = '0;
        send_idle_pct = 10;
        pop_idle_pct = 75;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_extremes();
        test_end_of_message();
        test_size_rewrite();
        test_size_limits();
        test_random_traffic(t_size'(3), 30);
        test_random_traffic(t_size'(1), 30);

        send_idle_pct = 75;
        pop_idle_pct = 10;
        test_random_traffic(t_size'($urandom_range(3)), 30);
        test_random_traffic(t_size'(0), 30);

        send_idle_pct = 0;
        pop_idle_pct = 0;
        test_random_traffic(t_size'(2), 30);
        test_random_traffic(t_size'($urandom_range(3)), 30);
        test_backpressure();

        settle();
        if (failures == 0) begin
            $display("hill_block_encrypt_top: match");
        end else begin
            $display("hill_block_encrypt_top: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
sv/hbe_pkg.sv
sv/hbe_front.sv
sv/hbe_queue.sv
sv/hbe_back.sv
sv/hill_block_encrypt_top.sv
sim/tb_hill_block_encrypt_top.sv
